// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SAC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_pkg
// Types, constants and address helpers for the sector card memory.
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int BLOCK_COUNT_DEF  = 256;
    localparam int SECTOR_COUNT_DEF = 40;

    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    localparam logic [63:0] BLOCK0_HI  = 64'h1122_3344_5500_0000;
    localparam logic [63:0] TRAILER_HI = 64'hFFFF_FFFF_FFFF_FF07;
    localparam logic [63:0] TRAILER_LO = 64'h8069_FFFF_FFFF_FFFF;

    localparam logic [47:0] KEY_RESET    = 48'hFFFF_FFFF_FFFF;
    localparam logic [7:0]  SLOT_A_RESET = 8'h01;
    localparam logic [7:0]  SLOT_B_RESET = 8'h02;

    localparam logic [5:0] SMALL_SECTORS   = 6'd16;
    localparam logic [5:0] LARGE_SECTORS   = 6'd40;
    localparam logic [7:0] SMALL_MAX_BLOCK = 8'd63;

    typedef enum logic [2:0] {
        OP_READ_BLOCK    = 3'd0,
        OP_WRITE_BLOCK   = 3'd1,
        OP_READ_TRAILER  = 3'd2,
        OP_WRITE_TRAILER = 3'd3,
        OP_AUTH          = 3'd4,
        OP_QUERY         = 3'd5,
        OP_CLEAR_AUTH    = 3'd6
    } op_t;

    typedef enum logic [3:0] {
        ST_OK             = 4'd0,
        ST_BAD_BLOCK      = 4'd1,
        ST_BAD_SECTOR     = 4'd2,
        ST_BLOCK0_WRITE   = 4'd3,
        ST_TRAILER_WRITE  = 4'd4,
        ST_UNAUTH         = 4'd5,
        ST_WRONG_KEY_TYPE = 4'd6,
        ST_SLOT_MISMATCH  = 4'd7,
        ST_KEY_MISMATCH   = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        MARK_NONE = 2'd0,
        MARK_A    = 2'd1,
        MARK_B    = 2'd2
    } mark_t;

    typedef enum logic [2:0] {
        REG_LARGE_MODE = 3'd0,
        REG_KEY_A      = 3'd1,
        REG_KEY_B      = 3'd2,
        REG_SLOT_A     = 3'd3,
        REG_SLOT_B     = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic        large_mode;
        logic [47:0] key_a;
        logic [47:0] key_b;
        logic [7:0]  slot_a;
        logic [7:0]  slot_b;
    } cfg_t;

    typedef struct packed {
        logic         rd_en;
        logic [7:0]   rd_addr;
        logic         wr_en;
        logic [7:0]   wr_addr;
        logic [127:0] wr_data;
    } blk_cmd_t;

    typedef struct packed {
        logic       rd_en;
        logic [5:0] rd_addr;
        logic       wr_en;
        logic [5:0] wr_addr;
        logic [1:0] wr_data;
        logic       clr_all;
    } mark_cmd_t;

    function automatic logic [5:0] sector_of(input logic [7:0] blk, input logic lg_mode);
        if (lg_mode && blk[7])
            return {3'b100, blk[6:4]};
        else
            return blk[7:2];
    endfunction

    // valid for sectors inside the layout
    function automatic logic [7:0] trailer_of(input logic [5:0] sec, input logic lg_mode);
        if (lg_mode && sec[5])
            return {1'b1, sec[2:0], 4'hF};
        else
            return {sec, 2'b11};
    endfunction

    function automatic logic is_trailer(input logic [7:0] blk, input logic lg_mode);
        return blk == trailer_of(sector_of(blk, lg_mode), lg_mode);
    endfunction

    function automatic logic [127:0] block_init(input logic [7:0] idx, input int sector_cnt);
        logic [5:0] s;
        s = sector_of(idx, 1'b1);
        if (idx == 8'd0)
            return {BLOCK0_HI, 64'd0};
        if (idx == trailer_of(s, 1'b1) && int'(s) < sector_cnt)
            return {TRAILER_HI, TRAILER_LO};
        return '0;
    endfunction

endpackage

// ----- design/sac_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_if
// Request and response channels of the sector card memory.
// ----------------------------------------------------------------------------
interface sac_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [7:0]  block_number;
    logic [5:0]  sector_number;
    logic        use_key_b;
    logic [7:0]  slot_number;
    logic [63:0] write_high_word;
    logic [63:0] write_low_word;

    modport source (
        output valid, operation, block_number, sector_number, use_key_b,
               slot_number, write_high_word, write_low_word,
        input  ready
    );
    modport sink (
        input  valid, operation, block_number, sector_number, use_key_b,
               slot_number, write_high_word, write_low_word,
        output ready
    );
endinterface

interface sac_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [63:0] read_high_word;
    logic [63:0] read_low_word;
    logic        is_authenticated;

    modport source (
        output valid, status, read_high_word, read_low_word, is_authenticated,
        input  ready
    );
    modport sink (
        input  valid, status, read_high_word, read_low_word, is_authenticated,
        output ready
    );
endinterface

// ----- design/sac_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_cfg_regs
// APB register file: layout mode, keys and key slot numbers.
// ----------------------------------------------------------------------------
module sac_cfg_regs
    import sac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    cfg_idx_t idx;
    logic     wr;

    assign pready = 1'b1;
    assign idx    = cfg_idx_t'(paddr[APB_ADDR_W-1:3]);
    assign wr     = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_LARGE_MODE: cfg_next.large_mode = pwdata[0];
                REG_KEY_A:      cfg_next.key_a      = pwdata[47:0];
                REG_KEY_B:      cfg_next.key_b      = pwdata[47:0];
                REG_SLOT_A:     cfg_next.slot_a     = pwdata[7:0];
                REG_SLOT_B:     cfg_next.slot_b     = pwdata[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_LARGE_MODE: prdata = {63'd0, cfg_reg.large_mode};
            REG_KEY_A:      prdata = {16'd0, cfg_reg.key_a};
            REG_KEY_B:      prdata = {16'd0, cfg_reg.key_b};
            REG_SLOT_A:     prdata = {56'd0, cfg_reg.slot_a};
            REG_SLOT_B:     prdata = {56'd0, cfg_reg.slot_b};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.large_mode <= 1'b0;
            cfg_reg.key_a      <= KEY_RESET;
            cfg_reg.key_b      <= KEY_RESET;
            cfg_reg.slot_a     <= SLOT_A_RESET;
            cfg_reg.slot_b     <= SLOT_B_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- design/sac_block_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_block_mem
// Card block store, 128 bits per block, registered read.
// Per-block valid bits; an unwritten block reads as its power-on content.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sac_block_mem
    import sac_pkg::*;
#(
    parameter int BLOCK_COUNT  = BLOCK_COUNT_DEF,
    parameter int SECTOR_COUNT = SECTOR_COUNT_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  blk_cmd_t       cmd,
    output logic [127:0]   rd_data
);

    localparam int AW = $clog2(BLOCK_COUNT);

    logic [127:0]           mem [BLOCK_COUNT];
    logic [BLOCK_COUNT-1:0] valid_reg;
    logic [127:0]           rd_raw_reg;
    logic [7:0]             rd_addr_reg;
    logic                   rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
        if (cmd.rd_en)
        begin
            rd_raw_reg  <= mem[cmd.rd_addr[AW-1:0]];
            rd_addr_reg <= cmd.rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
                valid_reg[cmd.wr_addr[AW-1:0]] <= 1'b1;
            if (cmd.rd_en)
                rd_hit_reg <= valid_reg[cmd.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_hit_reg ? rd_raw_reg : block_init(rd_addr_reg, SECTOR_COUNT);

    `SAC_ASSERT_IMPL(a_blk_rd_wr_excl, cmd.wr_en, !cmd.rd_en, "block read and write overlap")

endmodule

// ----- design/sac_mark_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_mark_mem
// Per-sector authentication marks, registered read.
// Valid bits give bulk clear; an invalid entry reads as no mark.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sac_mark_mem
    import sac_pkg::*;
#(
    parameter int SECTOR_COUNT = SECTOR_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  mark_cmd_t   cmd,
    output logic [1:0]  rd_mark
);

    localparam int AW = $clog2(SECTOR_COUNT);

    logic [1:0]              mem [SECTOR_COUNT];
    logic [SECTOR_COUNT-1:0] valid_reg;
    logic [1:0]              rd_raw_reg;
    logic                    rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
        if (cmd.rd_en)
            rd_raw_reg <= mem[cmd.rd_addr[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_all)
                valid_reg <= '0;
            else if (cmd.wr_en)
                valid_reg[cmd.wr_addr[AW-1:0]] <= 1'b1;
            if (cmd.rd_en)
                rd_hit_reg <= valid_reg[cmd.rd_addr[AW-1:0]];
        end
    end

    assign rd_mark = rd_hit_reg ? rd_raw_reg : MARK_NONE;

    `SAC_ASSERT_NEXT(a_mark_clear, cmd.clr_all, valid_reg == '0, "marks not cleared")

endmodule

// ----- design/sac_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_ctrl
// Request sequencer: issues memory reads on accept, then checks access,
// writes back and loads the response register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sac_ctrl
    import sac_pkg::*;
#(
    parameter int BLOCK_COUNT  = BLOCK_COUNT_DEF,
    parameter int SECTOR_COUNT = SECTOR_COUNT_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    sac_req_if.sink       req,
    sac_rsp_if.source     rsp,
    input  cfg_t          cfg,
    output blk_cmd_t      blk_cmd,
    input  logic [127:0]  blk_rd_data,
    output mark_cmd_t     mark_cmd,
    input  logic [1:0]    mark_rd
);

    state_t      state_reg;
    state_t      state_next;
    logic        accept;
    op_t         in_op;

    op_t         op_reg;
    logic [7:0]  blk_reg;
    logic [5:0]  sec_reg;
    logic        kb_reg;
    logic [7:0]  slot_reg;
    logic [63:0] whi_reg;
    logic [63:0] wlo_reg;

    logic        out_valid_reg;
    logic [3:0]  status_reg;
    logic [63:0] rhi_reg;
    logic [63:0] rlo_reg;
    logic        authd_reg;

    logic        out_load;
    status_t     status_next;
    logic [63:0] rhi_next;
    logic [63:0] rlo_next;
    logic        authd_next;

    logic        blk_ok;
    logic [5:0]  blk_sec;
    logic        blk_trl;
    logic [7:0]  sec_trl;
    logic [5:0]  sec_limit;
    logic        sec_ok;
    logic [5:0]  mark_sec;
    logic [1:0]  mark_cur;
    status_t     chk_a;
    status_t     chk_b;
    logic [7:0]  slot_exp;
    logic [47:0] key_exp;
    logic [47:0] key_stored;

    assign in_op     = op_t'(req.operation);
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign blk_ok    = (cfg.large_mode || blk_reg <= SMALL_MAX_BLOCK)
                       && ({1'b0, blk_reg} < 9'(BLOCK_COUNT));
    assign blk_sec   = sector_of(blk_reg, cfg.large_mode);
    assign blk_trl   = is_trailer(blk_reg, cfg.large_mode);
    assign sec_trl   = trailer_of(sec_reg, cfg.large_mode);
    assign sec_limit = cfg.large_mode ? LARGE_SECTORS : SMALL_SECTORS;
    assign sec_ok    = (sec_reg < sec_limit)
                       && ({1'b0, sec_reg} < 7'(SECTOR_COUNT))
                       && ({1'b0, sec_trl} < 9'(BLOCK_COUNT));
    assign mark_sec  = (op_reg == OP_READ_BLOCK || op_reg == OP_WRITE_BLOCK) ? blk_sec : sec_reg;
    assign mark_cur  = ({1'b0, mark_sec} < 7'(SECTOR_COUNT)) ? mark_rd : MARK_NONE;
    assign chk_a     = (mark_cur == MARK_NONE) ? ST_UNAUTH :
                       (mark_cur != MARK_A)    ? ST_WRONG_KEY_TYPE : ST_OK;
    assign chk_b     = (mark_cur == MARK_NONE) ? ST_UNAUTH :
                       (mark_cur != MARK_B)    ? ST_WRONG_KEY_TYPE : ST_OK;
    assign slot_exp  = kb_reg ? cfg.slot_b : cfg.slot_a;
    assign key_exp   = kb_reg ? cfg.key_b : cfg.key_a;
    assign key_stored = kb_reg ? blk_rd_data[47:0] : blk_rd_data[127:80];

    always_comb
    begin
        state_next  = state_reg;
        out_load    = 1'b0;
        status_next = ST_OK;
        rhi_next    = '0;
        rlo_next    = '0;
        authd_next  = 1'b0;

        blk_cmd.rd_en   = accept;
        blk_cmd.rd_addr = (in_op == OP_READ_BLOCK) ? req.block_number
                          : trailer_of(req.sector_number, cfg.large_mode);
        blk_cmd.wr_en   = 1'b0;
        blk_cmd.wr_addr = blk_reg;
        blk_cmd.wr_data = {whi_reg, wlo_reg};

        mark_cmd.rd_en   = accept;
        mark_cmd.rd_addr = (in_op == OP_READ_BLOCK || in_op == OP_WRITE_BLOCK)
                           ? sector_of(req.block_number, cfg.large_mode)
                           : req.sector_number;
        mark_cmd.wr_en   = 1'b0;
        mark_cmd.wr_addr = sec_reg;
        mark_cmd.wr_data = MARK_NONE;
        mark_cmd.clr_all = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    case (op_reg)
                        OP_READ_BLOCK:
                        begin
                            if (!blk_ok)
                                status_next = ST_BAD_BLOCK;
                            else if (blk_reg != 8'd0 && !blk_trl && chk_a != ST_OK)
                                status_next = chk_a;
                            else
                            begin
                                rhi_next = blk_rd_data[127:64];
                                rlo_next = blk_rd_data[63:0];
                            end
                        end
                        OP_WRITE_BLOCK:
                        begin
                            if (!blk_ok)
                                status_next = ST_BAD_BLOCK;
                            else if (blk_reg == 8'd0)
                                status_next = ST_BLOCK0_WRITE;
                            else if (blk_trl)
                                status_next = ST_TRAILER_WRITE;
                            else if (chk_b != ST_OK)
                                status_next = chk_b;
                            else
                                blk_cmd.wr_en = 1'b1;
                        end
                        OP_READ_TRAILER:
                        begin
                            if (!sec_ok)
                                status_next = ST_BAD_SECTOR;
                            else
                            begin
                                rhi_next = blk_rd_data[127:64];
                                rlo_next = blk_rd_data[63:0];
                            end
                        end
                        OP_WRITE_TRAILER:
                        begin
                            if (!sec_ok)
                                status_next = ST_BAD_SECTOR;
                            else if (chk_b != ST_OK)
                                status_next = chk_b;
                            else
                            begin
                                blk_cmd.wr_en    = 1'b1;
                                blk_cmd.wr_addr  = sec_trl;
                                mark_cmd.wr_en   = 1'b1;
                                mark_cmd.wr_data = MARK_NONE;
                            end
                        end
                        OP_AUTH:
                        begin
                            if (!sec_ok)
                                status_next = ST_BAD_SECTOR;
                            else if (slot_reg != slot_exp)
                                status_next = ST_SLOT_MISMATCH;
                            else if (key_stored != key_exp)
                                status_next = ST_KEY_MISMATCH;
                            else
                            begin
                                mark_cmd.wr_en   = 1'b1;
                                mark_cmd.wr_data = kb_reg ? MARK_B : MARK_A;
                            end
                        end
                        OP_QUERY:
                        begin
                            authd_next = (mark_cur == (kb_reg ? MARK_B : MARK_A));
                        end
                        OP_CLEAR_AUTH:
                        begin
                            mark_cmd.clr_all = 1'b1;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= in_op;
            blk_reg  <= req.block_number;
            sec_reg  <= req.sector_number;
            kb_reg   <= req.use_key_b;
            slot_reg <= req.slot_number;
            whi_reg  <= req.write_high_word;
            wlo_reg  <= req.write_low_word;
        end
        if (out_load)
        begin
            status_reg <= status_next;
            rhi_reg    <= rhi_next;
            rlo_reg    <= rlo_next;
            authd_reg  <= authd_next;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = status_reg;
    assign rsp.read_high_word   = rhi_reg;
    assign rsp.read_low_word    = rlo_reg;
    assign rsp.is_authenticated = authd_reg;

    `SAC_ASSERT_IMPL(a_blk_wr_ok, blk_cmd.wr_en, out_load && status_next == ST_OK, "block write on failed request")
    `SAC_ASSERT_IMPL(a_mark_b_auth, mark_cmd.wr_en && mark_cmd.wr_data == MARK_B, op_reg == OP_AUTH && kb_reg, "key B mark outside key B authenticate")

endmodule

// ----- design/sector_auth_card_memory.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_auth_card_memory
// Sector card memory with per-sector key A / key B authentication marks.
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | content
//  req     | in  | valid / ready   | command, block, sector, key type, slot, data
//  rsp     | out | valid / ready   | status, read data, query answer
//  apb     | in  | psel / penable  | mode, keys, slot numbers (8-byte stride)
//
//  The accept cycle issues the block and mark memory reads; the execute state
//  then checks access and writes back into the same memories.
//  Reset clears mark and block valid bits at once; no clearing pass.
//  The response register frees the request side; a new request is accepted
//  while a response waits, and execution holds until that response is taken.
// ----------------------------------------------------------------------------
module sector_auth_card_memory
    import sac_pkg::*;
#(
    parameter int BLOCK_COUNT  = BLOCK_COUNT_DEF,
    parameter int SECTOR_COUNT = SECTOR_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    sac_req_if.sink               req,
    sac_rsp_if.source             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t         cfg;
    blk_cmd_t     blk_cmd;
    mark_cmd_t    mark_cmd;
    logic [127:0] blk_rd_data;
    logic [1:0]   mark_rd;

    sac_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sac_block_mem #(
        .BLOCK_COUNT  (BLOCK_COUNT),
        .SECTOR_COUNT (SECTOR_COUNT)
    ) u_blk_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (blk_cmd),
        .rd_data (blk_rd_data)
    );

    sac_mark_mem #(
        .SECTOR_COUNT (SECTOR_COUNT)
    ) u_mark_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mark_cmd),
        .rd_mark (mark_rd)
    );

    sac_ctrl #(
        .BLOCK_COUNT  (BLOCK_COUNT),
        .SECTOR_COUNT (SECTOR_COUNT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg         (cfg),
        .blk_cmd     (blk_cmd),
        .blk_rd_data (blk_rd_data),
        .mark_cmd    (mark_cmd),
        .mark_rd     (mark_rd)
    );

endmodule

// ----- tb/tb_sector_auth_card_memory.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sector_auth_card_memory
// Self-checking bench for the sector card memory. Requests go through a
// queue-fed driver. A shadow card model predicts every response, and the
// response monitor compares it field by field. The bench steps through five
// register settings in both layouts, with directed access-rule cases, keyed
// request sequences and noise, random idling and one long response stall.
// ----------------------------------------------------------------------------
module tb_sector_auth_card_memory;
    import sac_pkg::*;

    localparam int NUM_BLOCKS       = BLOCK_COUNT_DEF;
    localparam int NUM_SECTORS      = SECTOR_COUNT_DEF;
    localparam int NUM_PHASES       = 5;
    localparam int RANDOM_PER_PHASE = 300;
    localparam int HOLD_CYCLES      = 200;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  blk_num;
        logic [5:0]  sec_num;
        logic        key_b;
        logic [7:0]  slot;
        logic [63:0] wr_hi;
        logic [63:0] wr_lo;
    } card_cmd_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] rd_hi;
        logic [63:0] rd_lo;
        logic        authd;
    } card_resp_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic      req_valid = 1'b0;
    card_cmd_t req_cmd   = '0;
    logic      rsp_ready = 1'b0;

    sac_req_if req_bus ();
    sac_rsp_if rsp_bus ();

    assign req_bus.valid           = req_valid;
    assign req_bus.operation       = req_cmd.op;
    assign req_bus.block_number    = req_cmd.blk_num;
    assign req_bus.sector_number   = req_cmd.sec_num;
    assign req_bus.use_key_b       = req_cmd.key_b;
    assign req_bus.slot_number     = req_cmd.slot;
    assign req_bus.write_high_word = req_cmd.wr_hi;
    assign req_bus.write_low_word  = req_cmd.wr_lo;
    assign rsp_bus.ready           = rsp_ready;

    sector_auth_card_memory #(
        .BLOCK_COUNT  (NUM_BLOCKS),
        .SECTOR_COUNT (NUM_SECTORS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_bus),
        .rsp     (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow card state and register copy
    logic [63:0] card_hi [NUM_BLOCKS];
    logic [63:0] card_lo [NUM_BLOCKS];
    mark_t       auth_mark [NUM_SECTORS];
    cfg_t        cfg_shadow;

    card_cmd_t  cmd_q [$];
    card_resp_t expect_q [$];

    int   queued_total   = 0;
    int   accepted_total = 0;
    int   checked_total  = 0;
    int   fail_count     = 0;
    int   auth_granted   = 0;
    int   access_refused = 0;
    int   send_gap       = 0;
    int   stall_left     = 0;
    logic send_idle_on   = 1'b1;
    logic recv_idle_on   = 1'b1;
    logic rsp_hold       = 1'b0;
    logic hold_go        = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int sector_of_block(input int blk, input logic lg);
        if (!lg || blk < 128)
            return blk / 4;
        return 32 + (blk - 128) / 16;
    endfunction

    function automatic int trailer_block(input int sec, input logic lg);
        if (!lg || sec < 32)
            return sec * 4 + 3;
        return 128 + (sec - 32) * 16 + 15;
    endfunction

    function automatic logic block_valid(input int blk);
        int top;
        top = cfg_shadow.large_mode ? 255 : 63;
        return blk <= top && blk < NUM_BLOCKS;
    endfunction

    function automatic logic sector_valid(input int sec);
        int cnt;
        cnt = cfg_shadow.large_mode ? 40 : 16;
        return sec < cnt && sec < NUM_SECTORS &&
               trailer_block(sec, cfg_shadow.large_mode) < NUM_BLOCKS;
    endfunction

    function automatic status_t mark_check(input int sec, input mark_t need);
        mark_t m;
        m = (sec < NUM_SECTORS) ? auth_mark[sec] : MARK_NONE;
        if (m == MARK_NONE)
            return ST_UNAUTH;
        if (m != need)
            return ST_WRONG_KEY_TYPE;
        return ST_OK;
    endfunction

    function automatic void reset_card_model();
        int t;
        for (int b = 0; b < NUM_BLOCKS; b++)
        begin
            card_hi[b] = '0;
            card_lo[b] = '0;
        end
        card_hi[0] = BLOCK0_HI;
        for (int s = 0; s < NUM_SECTORS; s++)
        begin
            t = trailer_block(s, 1'b1);
            if (t < NUM_BLOCKS)
            begin
                card_hi[t] = TRAILER_HI;
                card_lo[t] = TRAILER_LO;
            end
        end
        for (int s = 0; s < NUM_SECTORS; s++)
            auth_mark[s] = MARK_NONE;
        cfg_shadow.large_mode = 1'b0;
        cfg_shadow.key_a      = KEY_RESET;
        cfg_shadow.key_b      = KEY_RESET;
        cfg_shadow.slot_a     = SLOT_A_RESET;
        cfg_shadow.slot_b     = SLOT_B_RESET;
    endfunction

    function automatic card_resp_t apply_card_cmd(input card_cmd_t c);
        card_resp_t  r;
        logic        lg;
        int          blk;
        int          sec;
        int          tr;
        logic [47:0] stored;
        lg      = cfg_shadow.large_mode;
        blk     = int'(c.blk_num);
        sec     = int'(c.sec_num);
        r.status = ST_OK;
        r.rd_hi  = '0;
        r.rd_lo  = '0;
        r.authd  = 1'b0;
        case (c.op)
            OP_READ_BLOCK:
            begin
                if (!block_valid(blk))
                    r.status = ST_BAD_BLOCK;
                else
                begin
                    if (blk != 0 && blk != trailer_block(sector_of_block(blk, lg), lg))
                        r.status = mark_check(sector_of_block(blk, lg), MARK_A);
                    if (r.status == ST_OK)
                    begin
                        r.rd_hi = card_hi[blk];
                        r.rd_lo = card_lo[blk];
                    end
                end
            end
            OP_WRITE_BLOCK:
            begin
                if (!block_valid(blk))
                    r.status = ST_BAD_BLOCK;
                else if (blk == 0)
                    r.status = ST_BLOCK0_WRITE;
                else if (blk == trailer_block(sector_of_block(blk, lg), lg))
                    r.status = ST_TRAILER_WRITE;
                else
                begin
                    r.status = mark_check(sector_of_block(blk, lg), MARK_B);
                    if (r.status == ST_OK)
                    begin
                        card_hi[blk] = c.wr_hi;
                        card_lo[blk] = c.wr_lo;
                    end
                end
            end
            OP_READ_TRAILER:
            begin
                if (!sector_valid(sec))
                    r.status = ST_BAD_SECTOR;
                else
                begin
                    tr      = trailer_block(sec, lg);
                    r.rd_hi = card_hi[tr];
                    r.rd_lo = card_lo[tr];
                end
            end
            OP_WRITE_TRAILER:
            begin
                if (!sector_valid(sec))
                    r.status = ST_BAD_SECTOR;
                else
                begin
                    r.status = mark_check(sec, MARK_B);
                    if (r.status == ST_OK)
                    begin
                        tr             = trailer_block(sec, lg);
                        card_hi[tr]    = c.wr_hi;
                        card_lo[tr]    = c.wr_lo;
                        auth_mark[sec] = MARK_NONE;
                    end
                end
            end
            OP_AUTH:
            begin
                if (!sector_valid(sec))
                    r.status = ST_BAD_SECTOR;
                else if (c.slot != (c.key_b ? cfg_shadow.slot_b : cfg_shadow.slot_a))
                    r.status = ST_SLOT_MISMATCH;
                else
                begin
                    tr     = trailer_block(sec, lg);
                    stored = c.key_b ? card_lo[tr][47:0] : card_hi[tr][63:16];
                    if (stored != (c.key_b ? cfg_shadow.key_b : cfg_shadow.key_a))
                        r.status = ST_KEY_MISMATCH;
                    else
                    begin
                        auth_mark[sec] = c.key_b ? MARK_B : MARK_A;
                        auth_granted++;
                    end
                end
            end
            OP_QUERY:
            begin
                if (sec < NUM_SECTORS)
                    r.authd = auth_mark[sec] == (c.key_b ? MARK_B : MARK_A);
            end
            OP_CLEAR_AUTH:
            begin
                for (int s = 0; s < NUM_SECTORS; s++)
                    auth_mark[s] = MARK_NONE;
            end
            default:
            begin
            end
        endcase
        if (r.status == ST_UNAUTH || r.status == ST_WRONG_KEY_TYPE)
            access_refused++;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [127:0] trailer_word(input logic [47:0] ka, input logic [47:0] kb,
                                                  input logic [31:0] access);
        return {ka, access, kb};
    endfunction

    function automatic int pick_slot(input logic [7:0] good);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 255);
        return int'(good);
    endfunction

    function automatic int pick_sector();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(0, 63);
        return $urandom_range(0, cfg_shadow.large_mode ? 39 : 15);
    endfunction

    function automatic int pick_block(input int first, input int last);
        if ($urandom_range(0, 9) == 0)
            return 0;
        return $urandom_range(first, last);
    endfunction

    task automatic push_cmd(input logic [2:0] op, input int blk, input int sec, input logic kb,
                            input int slot, input logic [127:0] data);
        card_cmd_t c;
        c.op      = op;
        c.blk_num = blk[7:0];
        c.sec_num = sec[5:0];
        c.key_b   = kb;
        c.slot    = slot[7:0];
        c.wr_hi   = data[127:64];
        c.wr_lo   = data[63:0];
        cmd_q.push_back(c);
        queued_total++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_LARGE_MODE: cfg_shadow.large_mode = value[0];
            REG_KEY_A:      cfg_shadow.key_a      = value[47:0];
            REG_KEY_B:      cfg_shadow.key_b      = value[47:0];
            REG_SLOT_A:     cfg_shadow.slot_a     = value[7:0];
            REG_SLOT_B:     cfg_shadow.slot_b     = value[7:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic wait_idle();
        do @(negedge clk); while (cmd_q.size() != 0 || req_valid || expect_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : req_driver
        card_cmd_t next_cmd;
        logic      next_valid;
        next_cmd   = req_cmd;
        next_valid = req_valid;
        if (rst_n)
        begin
            if (req_valid && req_bus.ready)
            begin
                expect_q.push_back(apply_card_cmd(req_cmd));
                accepted_total++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (cmd_q.size() != 0)
                begin
                    next_cmd   = cmd_q.pop_front();
                    next_valid = 1'b1;
                    send_gap   = send_idle_on ? pick_gap() : 0;
                end
            end
        end
        req_cmd   <= next_cmd;
        req_valid <= next_valid;
    end

    always @(posedge clk)
    begin : rsp_monitor
        card_resp_t want;
        logic       next_ready;
        if (rst_n && rsp_ready && rsp_bus.valid)
        begin
            if (expect_q.size() == 0)
            begin
                $error("response with no request outstanding, status %0d", rsp_bus.status);
                fail_count++;
            end
            else
            begin
                want = expect_q.pop_front();
                compare_field("status", 64'(want.status), 64'(rsp_bus.status));
                compare_field("read_high_word", want.rd_hi, rsp_bus.read_high_word);
                compare_field("read_low_word", want.rd_lo, rsp_bus.read_low_word);
                compare_field("is_authenticated", 64'(want.authd),
                              64'(rsp_bus.is_authenticated));
                checked_total++;
            end
        end
        next_ready = 1'b0;
        if (rst_n && !rsp_hold)
        begin
            if (stall_left > 0)
                stall_left--;
            else
            begin
                next_ready = 1'b1;
                stall_left = recv_idle_on ? pick_gap() : 0;
            end
        end
        rsp_ready <= next_ready;
    end

    // long response stall while the sender keeps offering
    initial
    begin : rsp_hold_off
        wait (hold_go);
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    initial
    begin : main_seq
        logic        mode_set   [NUM_PHASES];
        logic [47:0] key_a_set  [NUM_PHASES];
        logic [47:0] key_b_set  [NUM_PHASES];
        logic [7:0]  slot_a_set [NUM_PHASES];
        logic [7:0]  slot_b_set [NUM_PHASES];
        logic        lg;
        logic        kb;
        int          sec;
        int          first;
        int          last;
        int          n;
        int          kind;
        int          phase_base;
        int          slot_a_rst;
        int          slot_b_rst;

        reset_card_model();
        slot_a_rst = int'(SLOT_A_RESET);
        slot_b_rst = int'(SLOT_B_RESET);
        mode_set   = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        key_a_set  = '{KEY_RESET, KEY_RESET, 48'h0, {$urandom, 16'($urandom)}, KEY_RESET};
        key_b_set  = '{KEY_RESET, KEY_RESET, {$urandom, 16'($urandom)}, 48'h0,
                       {$urandom, 16'($urandom)}};
        slot_a_set = '{SLOT_A_RESET, 8'd0, 8'd255, 8'($urandom), 8'd0};
        slot_b_set = '{SLOT_B_RESET, 8'd255, 8'd0, 8'($urandom), 8'd0};
        slot_a_set[4] = 8'($urandom);
        slot_b_set[4] = slot_a_set[4];

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_idle_on <= (p != 1) && (p != 4);
            recv_idle_on <= (p != 1) && (p != 3);
            write_reg(REG_LARGE_MODE, 64'(mode_set[p]));
            write_reg(REG_KEY_A, 64'(key_a_set[p]));
            write_reg(REG_KEY_B, 64'(key_b_set[p]));
            write_reg(REG_SLOT_A, 64'(slot_a_set[p]));
            write_reg(REG_SLOT_B, 64'(slot_b_set[p]));

            if (p == 0)
            begin
                // access rules in the small layout with reset keys
                push_cmd(OP_READ_BLOCK, 0, $urandom, 1'b0, $urandom, rand128());
                push_cmd(OP_READ_BLOCK, 3, $urandom, 1'b1, $urandom, rand128());
                push_cmd(OP_READ_BLOCK, 1, $urandom, 1'b0, $urandom, rand128());
                push_cmd(OP_WRITE_BLOCK, 0, $urandom, 1'b0, $urandom, rand128());
                push_cmd(OP_WRITE_BLOCK, 7, $urandom, 1'b1, $urandom, rand128());
                push_cmd(OP_READ_BLOCK, 64, $urandom, 1'b0, $urandom, rand128());
                push_cmd(OP_READ_BLOCK, 255, $urandom, 1'b0, $urandom, rand128());
                push_cmd(OP_READ_TRAILER, $urandom, 16, 1'b0, $urandom, rand128());
                push_cmd(OP_READ_TRAILER, $urandom, 15, 1'b0, $urandom, rand128());
                push_cmd(OP_AUTH, $urandom, 0, 1'b0, 255, rand128());
                push_cmd(OP_AUTH, $urandom, 0, 1'b0, slot_a_rst, rand128());
                push_cmd(OP_READ_BLOCK, 1, $urandom, 1'b0, $urandom, rand128());
                push_cmd(OP_WRITE_BLOCK, 1, $urandom, 1'b0, $urandom, rand128());
                push_cmd(OP_AUTH, $urandom, 0, 1'b1, slot_b_rst, rand128());
                push_cmd(OP_WRITE_BLOCK, 1, $urandom, 1'b0, $urandom, {128{1'b1}});
                push_cmd(OP_WRITE_BLOCK, 2, $urandom, 1'b0, $urandom, 128'h0);
                push_cmd(OP_READ_BLOCK, 1, $urandom, 1'b0, $urandom, rand128());
                push_cmd(OP_QUERY, $urandom, 0, 1'b1, $urandom, rand128());
                push_cmd(OP_QUERY, $urandom, 63, 1'b1, $urandom, rand128());
                push_cmd(OP_AUTH, $urandom, 1, 1'b1, slot_b_rst, rand128());
                push_cmd(OP_WRITE_TRAILER, $urandom, 1, 1'b0, $urandom,
                         trailer_word(48'h1234_5678_9ABC, KEY_RESET, 32'hFF07_8069));
                push_cmd(OP_AUTH, $urandom, 1, 1'b0, slot_a_rst, rand128());
                push_cmd(OP_WRITE_TRAILER, $urandom, 0, 1'b0, $urandom,
                         trailer_word(KEY_RESET, KEY_RESET, $urandom));
                push_cmd(OP_AUTH, $urandom, 2, 1'b0, slot_a_rst, rand128());
                push_cmd(OP_CLEAR_AUTH, $urandom, $urandom, 1'b0, $urandom, rand128());
                push_cmd(OP_QUERY, $urandom, 2, 1'b0, $urandom, rand128());
                push_cmd(OP_WRITE_TRAILER, $urandom, 2, 1'b1, $urandom, rand128());
                push_cmd(3'd7, $urandom, $urandom, 1'b1, $urandom, rand128());
            end

            if (p == 1)
                hold_go = 1'b1;

            phase_base = queued_total;
            while (queued_total - phase_base < RANDOM_PER_PHASE)
            begin
                lg    = cfg_shadow.large_mode;
                kind  = $urandom_range(0, 99);
                sec   = pick_sector();
                last  = trailer_block(sec, lg);
                first = last - ((lg && sec >= 32) ? 15 : 3);
                n     = $urandom_range(1, 4);
                if (kind < 30)
                begin
                    push_cmd(OP_AUTH, $urandom, sec, 1'b0, pick_slot(cfg_shadow.slot_a),
                             rand128());
                    repeat (n)
                        push_cmd(OP_READ_BLOCK, pick_block(first, last), $urandom,
                                 rand_bit(), $urandom, rand128());
                    if ($urandom_range(0, 1) == 1)
                        push_cmd(OP_QUERY, $urandom, sec, rand_bit(), $urandom, rand128());
                end
                else if (kind < 60)
                begin
                    push_cmd(OP_AUTH, $urandom, sec, 1'b1, pick_slot(cfg_shadow.slot_b),
                             rand128());
                    repeat (n)
                        push_cmd(OP_WRITE_BLOCK, pick_block(first, last), $urandom,
                                 rand_bit(), $urandom, rand128());
                    if ($urandom_range(0, 3) == 0)
                        push_cmd(OP_READ_BLOCK, pick_block(first, last), $urandom,
                                 rand_bit(), $urandom, rand128());
                    if ($urandom_range(0, 2) == 0)
                        push_cmd(OP_WRITE_TRAILER, $urandom, sec, rand_bit(), $urandom,
                                 trailer_word(cfg_shadow.key_a, cfg_shadow.key_b, $urandom));
                    push_cmd(OP_QUERY, $urandom, sec, 1'b1, $urandom, rand128());
                end
                else if (kind < 72)
                begin
                    kb = rand_bit();
                    push_cmd(OP_AUTH, $urandom, sec, kb,
                             pick_slot(kb ? cfg_shadow.slot_b : cfg_shadow.slot_a), rand128());
                    push_cmd(OP_QUERY, $urandom, sec, rand_bit(), $urandom, rand128());
                end
                else if (kind < 82)
                    push_cmd(OP_READ_TRAILER, $urandom, sec, rand_bit(), $urandom,
                             rand128());
                else if (kind < 85)
                    push_cmd(OP_CLEAR_AUTH, $urandom, $urandom, rand_bit(), $urandom,
                             rand128());
                else
                    push_cmd(3'($urandom_range(0, 7)), $urandom, $urandom, rand_bit(),
                             $urandom, rand128());
            end

            // rekey every trailer of the layout for the next setting
            if (p + 1 < NUM_PHASES)
                for (int s = 0; s < int'(cfg_shadow.large_mode ? LARGE_SECTORS : SMALL_SECTORS);
                     s++)
                begin
                    push_cmd(OP_AUTH, $urandom, s, 1'b1, int'(cfg_shadow.slot_b), rand128());
                    push_cmd(OP_WRITE_TRAILER, $urandom, s, rand_bit(), $urandom,
                             trailer_word(key_a_set[p + 1], key_b_set[p + 1], $urandom));
                end

            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (expect_q.size() != 0)
        begin
            $error("%0d responses never arrived", expect_q.size());
            fail_count++;
        end

        $display("Checked %0d responses to %0d requests over %0d register settings, both layouts.",
                 checked_total, accepted_total, NUM_PHASES);
        $display("Authentications granted: %0d, accesses refused for missing or wrong key: %0d.",
                 auth_granted, access_refused);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
